/* hw/rtl/ordered_list_push_front_remove_all_unit_assert.svh */
// assertion macros for the ordered list unit
`ifndef ORDERED_LIST_PUSH_FRONT_REMOVE_ALL_UNIT_ASSERT_SVH
`define ORDERED_LIST_PUSH_FRONT_REMOVE_ALL_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// condition and consequence in the same cycle
`define OLPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequence in the cycle after the condition
`define OLPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define OLPF_ASSERT_NOW(lbl, ante, cons, msg)
`define OLPF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* hw/rtl/olpf_pkg.sv */
`default_nettype none

package olpf_pkg;

  localparam int OLPF_CAPACITY = 16;
  localparam int OLPF_COUNT_W  = 5;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_t;

  typedef enum logic {
    ST_IDLE    = 1'b0,
    ST_COMPACT = 1'b1
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD    = 3'd0,
    CELL_INSERT  = 3'd1,
    CELL_MARK    = 3'd2,
    CELL_COMPACT = 3'd3,
    CELL_CLEAR   = 3'd4
  } cell_op_t;

  typedef struct packed {
    action_t            action;
    logic signed [31:0] value;
    logic               last_command;
  } cmd_t;

  typedef struct packed {
    logic [OLPF_COUNT_W-1:0] entry_count;
    logic                    overflow;
    logic                    batch_end;
  } rsp_t;

  // contents handed between neighboring cells
  typedef struct packed {
    logic               valid;
    logic signed [31:0] data;
  } link_t;

  // broadcast control to every cell
  typedef struct packed {
    cell_op_t           op;
    logic signed [31:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/olpf_cell.sv */
`default_nettype none

module olpf_cell
  import olpf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cell_ctrl_t ctrl,
  input  wire link_t      prev_link,
  input  wire link_t      next_link,
  output link_t           cur_link
);

  logic               valid;
  logic signed [31:0] data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctrl.op)
        CELL_INSERT: begin
          valid <= prev_link.valid;
          data  <= prev_link.data;
        end
        CELL_MARK: begin
          valid <= valid && (data != ctrl.value);
        end
        CELL_COMPACT: begin
          // an empty cell pulls its successor; a cell pulled by an empty
          // predecessor goes empty
          if (!valid) begin
            valid <= next_link.valid;
            data  <= next_link.data;
          end else if (!prev_link.valid) begin
            valid <= 1'b0;
          end
        end
        CELL_CLEAR: begin
          valid <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign cur_link.valid = valid;
  assign cur_link.data  = data;

endmodule

`default_nettype wire

/* hw/rtl/ordered_list_push_front_remove_all_unit.sv */
`default_nettype none
`include "ordered_list_push_front_remove_all_unit_assert.svh"

// ordered list of up to CAPACITY signed 32-bit values, held in a row of cells
//
// command channel: a word on cmd is taken at a clock edge with start high and
// busy low. action insert puts value at the front of the list; action remove
// deletes every entry equal to value and closes up the gaps in order.
// result channel: one word on rsp per command, valid for exactly one cycle
// while done is high; the receiver cannot stall it, so it must take it then.
//
// insert: result in the cycle after acceptance, busy stays low, so a new
// insert may follow in every cycle. an insert into a full list is dropped
// and reported with overflow set.
// remove: a mark step makes matching cells empty, then the row closes gaps by
// one place per cycle (each empty cell pulls its neighbor) until no empty
// cell stands before a full one; busy is high while the row compacts,
// and done rises in the first cycle with busy low, so a remove holds the
// command channel until its result is given.
// batch end: a command with last_command set reports the count, then the
// list is emptied for the next batch.
// reset: synchronous, empties the list; no result is pending afterward.
module ordered_list_push_front_remove_all_unit
  import olpf_pkg::*;
#(
  parameter int CAPACITY = OLPF_CAPACITY
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire cmd_t cmd,
  output logic      busy,
  output logic      done,
  output rsp_t      rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t           st, st_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             last_q, last_next;
  logic             done_next;
  rsp_t             rsp_q, rsp_next;
  cell_ctrl_t       ctrl;

  link_t                cells [CAPACITY];
  logic [CAPACITY-1:0]  valid_vec;
  link_t                ins_link;
  link_t                end_link;

  logic             gap;       // an empty cell stands before a full one
  logic [CNT_W-1:0] tail_cnt;  // count of a gap-free row
  logic             full;
  logic [CNT_W-1:0] ins_cnt;

  // the new front entry enters cell 0; its valid also tells cell 0 during
  // compaction that it is never pulled
  assign ins_link.valid = 1'b1;
  assign ins_link.data  = cmd.value;
  assign end_link.valid = 1'b0;
  assign end_link.data  = '0;

  // the row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      if (CAPACITY > 1) begin : g_more
        olpf_cell u_cell (
          .clk       (clk),
          .rst       (rst),
          .ctrl      (ctrl),
          .prev_link (ins_link),
          .next_link (cells[i+1]),
          .cur_link  (cells[i])
        );
      end else begin : g_only
        olpf_cell u_cell (
          .clk       (clk),
          .rst       (rst),
          .ctrl      (ctrl),
          .prev_link (ins_link),
          .next_link (end_link),
          .cur_link  (cells[i])
        );
      end
    end else if (i == CAPACITY - 1) begin : g_tail
      olpf_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .prev_link (cells[i-1]),
        .next_link (end_link),
        .cur_link  (cells[i])
      );
    end else begin : g_mid
      olpf_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .prev_link (cells[i-1]),
        .next_link (cells[i+1]),
        .cur_link  (cells[i])
      );
    end
    assign valid_vec[i] = cells[i].valid;
  end

  // gap detect and count of the compacted row: the last full cell of a
  // gap-free row gives the count as its position plus one
  always_comb begin
    gap      = 1'b0;
    tail_cnt = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (i < CAPACITY - 1) begin
        gap = gap | (!valid_vec[i] && valid_vec[i+1]);
        if (valid_vec[i] && !valid_vec[i+1]) begin
          tail_cnt = tail_cnt | CNT_W'(i + 1);
        end
      end else if (valid_vec[i]) begin
        tail_cnt = tail_cnt | CNT_W'(i + 1);
      end
    end
  end

  assign full    = valid_vec[CAPACITY-1];
  assign ins_cnt = full ? cnt : cnt + CNT_W'(1);

  // state register and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= ST_IDLE;
      cnt    <= '0;
      done   <= 1'b0;
      last_q <= 1'b0;
    end else begin
      st     <= st_next;
      cnt    <= cnt_next;
      done   <= done_next;
      last_q <= last_next;
    end
  end

  always_ff @(posedge clk) begin
    rsp_q <= rsp_next;
  end

  // sequencer: next state, cell commands and result
  always_comb begin
    st_next    = st;
    cnt_next   = cnt;
    last_next  = last_q;
    done_next  = 1'b0;
    rsp_next   = rsp_q;
    ctrl.op    = CELL_HOLD;
    ctrl.value = cmd.value;
    case (st)
      ST_IDLE: begin
        if (start) begin
          if (cmd.action == ACT_INSERT) begin
            rsp_next.entry_count = OLPF_COUNT_W'(ins_cnt);
            rsp_next.overflow    = full;
            rsp_next.batch_end   = cmd.last_command;
            done_next            = 1'b1;
            cnt_next             = cmd.last_command ? '0 : ins_cnt;
            if (cmd.last_command) begin
              ctrl.op = CELL_CLEAR;
            end else if (!full) begin
              ctrl.op = CELL_INSERT;
            end
          end else begin
            // drop matching entries now, close gaps in the following cycles
            ctrl.op   = CELL_MARK;
            last_next = cmd.last_command;
            st_next   = ST_COMPACT;
          end
        end
      end
      ST_COMPACT: begin
        if (gap) begin
          ctrl.op = CELL_COMPACT;
        end else begin
          rsp_next.entry_count = OLPF_COUNT_W'(tail_cnt);
          rsp_next.overflow    = 1'b0;
          rsp_next.batch_end   = last_q;
          done_next            = 1'b1;
          cnt_next             = last_q ? '0 : tail_cnt;
          ctrl.op              = last_q ? CELL_CLEAR : CELL_HOLD;
          st_next              = ST_IDLE;
        end
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (st == ST_COMPACT);
  assign rsp  = rsp_q;

  // a remove command always holds off the next command
  `OLPF_ASSERT_NEXT(a_remove_busy, start && !busy && cmd.action == ACT_REMOVE, busy,
                    "remove command did not raise busy")
  // compaction always ends in a result word
  `OLPF_ASSERT_NEXT(a_busy_ends, busy && !gap, !busy && done,
                    "compaction finished without a result word")
  // between commands the row is gap free and matches the count
  `OLPF_ASSERT_NOW(a_idle_packed, !busy, !gap && tail_cnt == cnt,
                   "idle row has a gap or disagrees with the count")
  // the count never exceeds the capacity
  `OLPF_ASSERT_NOW(a_cnt_range, 1'b1, cnt <= CNT_W'(CAPACITY),
                   "entry count beyond capacity")

endmodule

`default_nettype wire

/* tb/sv/tb_ordered_list_push_front_remove_all_unit.sv */
`timescale 1ns / 100ps

module tb_ordered_list_push_front_remove_all_unit;
  import olpf_pkg::*;

  localparam int CAPACITY     = OLPF_CAPACITY;
  localparam int RANDOM_WORDS = 1450;
  // slowest word is a remove: busy while the row compacts, then the result
  localparam int DRAIN_CYCLES = CAPACITY + 4;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int PRINT_CAP    = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cmd_t cmd = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  ordered_list_push_front_remove_all_unit #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .cmd  (cmd),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // command words still to be sent, and the results they must produce
  cmd_t pending_cmds[$];
  rsp_t expected_rsp[$];

  int unsigned total_words = 0;
  int unsigned accepted_words = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // shadow copy of the list, index 0 is the front
  logic signed [31:0] list_model[CAPACITY];
  int unsigned list_fill = 0;

  // one list command applied to the shadow copy, returns the result word
  task automatic apply_list_command(input cmd_t c, output rsp_t r);
    int unsigned wr;
    logic ovf;
    ovf = 1'b0;
    if (c.action == ACT_INSERT) begin
      if (list_fill >= CAPACITY) begin
        // full list: word is dropped, contents untouched
        ovf = 1'b1;
      end else begin
        for (int i = list_fill; i > 0; i--) list_model[i] = list_model[i-1];
        list_model[0] = c.value;
        list_fill++;
      end
    end else begin
      // remove every match, survivors keep their order
      wr = 0;
      for (int rd = 0; rd < list_fill; rd++) begin
        if (list_model[rd] != c.value) begin
          list_model[wr] = list_model[rd];
          wr++;
        end
      end
      list_fill = wr;
    end
    r.entry_count = list_fill[OLPF_COUNT_W-1:0];
    r.overflow    = ovf;
    r.batch_end   = c.last_command;
    // batch end reports the count first, then the list starts over empty
    if (c.last_command) list_fill = 0;
  endtask

  task automatic queue_cmd(input action_t a, input logic [31:0] v, input logic last);
    cmd_t c;
    c.action       = a;
    c.value        = v;
    c.last_command = last;
    pending_cmds.push_back(c);
    total_words++;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_CAP)
      $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  // driver: a word moves at an edge with start high and busy low; start is
  // held with the same word until it moves, then the next word or a gap
  always @(posedge clk) begin : drive_cmds
    rsp_t predicted;
    logic calm;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_list_command(cmd, predicted);
        expected_rsp.push_back(predicted);
        accepted_words++;
      end
      // a stretch in the middle of the run with no gaps at all
      calm = (accepted_words >= 600) && (accepted_words < 900);
      if (!start || !busy) begin
        if (pending_cmds.size() > 0 && (calm || $urandom_range(0, 99) >= 35)) begin
          start <= 1'b1;
          cmd   <= pending_cmds.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: done marks a result word for exactly one cycle
  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (!rst && done) begin
      if (expected_rsp.size() == 0) begin
        report_mismatch("unexpected result, entry_count", int'(rsp.entry_count), 0);
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.entry_count !== want.entry_count)
          report_mismatch("entry_count", int'(rsp.entry_count), int'(want.entry_count));
        if (rsp.overflow !== want.overflow)
          report_mismatch("overflow", int'(rsp.overflow), int'(want.overflow));
        if (rsp.batch_end !== want.batch_end)
          report_mismatch("batch_end", int'(rsp.batch_end), int'(want.batch_end));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned mode;
    int unsigned len;
    logic [31:0] base;
    logic [31:0] v;
    action_t a;
    logic last;

    // directed: remove on an empty list, extremes, duplicates, absent value
    queue_cmd(ACT_REMOVE, 32'h0000_0003, 1'b0);
    queue_cmd(ACT_INSERT, 32'h7fff_ffff, 1'b0);
    queue_cmd(ACT_INSERT, 32'h8000_0000, 1'b0);
    queue_cmd(ACT_INSERT, 32'h0000_0000, 1'b0);
    queue_cmd(ACT_INSERT, 32'hffff_ffff, 1'b0);
    queue_cmd(ACT_INSERT, 32'h7fff_ffff, 1'b0);
    queue_cmd(ACT_REMOVE, 32'h7fff_ffff, 1'b0);
    queue_cmd(ACT_REMOVE, 32'h0000_0005, 1'b0);
    queue_cmd(ACT_REMOVE, 32'h8000_0000, 1'b1);
    // fill to capacity, overflow on a full list, then a wide remove
    for (int i = 0; i < CAPACITY; i++)
      queue_cmd(ACT_INSERT, (i % 2) ? 32'hffff_fff9 : 32'h0000_002a, 1'b0);
    queue_cmd(ACT_INSERT, 32'h1234_5678, 1'b0);
    queue_cmd(ACT_REMOVE, 32'h0000_002a, 1'b0);
    queue_cmd(ACT_INSERT, 32'h0000_0001, 1'b1);

    // random: mostly whole batches over a small value pool so removes hit,
    // some insert-heavy batches that reach overflow, some pure noise
    while (total_words < RANDOM_WORDS + 27) begin
      mode = $urandom_range(0, 9);
      len  = (mode >= 7 && mode < 9) ? $urandom_range(CAPACITY, CAPACITY + 8)
                                     : $urandom_range(1, 30);
      case ($urandom_range(0, 5))
        0: base = 32'h7fff_ffff;
        1: base = 32'h8000_0000;
        2: base = 32'h0000_0000;
        default: base = $urandom;
      endcase
      for (int k = 0; k < len; k++) begin
        if (mode == 9) begin
          a    = $urandom_range(0, 1) ? ACT_REMOVE : ACT_INSERT;
          v    = $urandom;
          last = ($urandom_range(0, 7) == 0);
        end else begin
          if (mode >= 7)
            a = ($urandom_range(0, 9) == 0) ? ACT_REMOVE : ACT_INSERT;
          else
            a = ($urandom_range(0, 9) < 3) ? ACT_REMOVE : ACT_INSERT;
          v    = ($urandom_range(0, 3) == 0) ? $urandom : (base ^ $urandom_range(0, 3));
          last = (k == len - 1);
        end
        queue_cmd(a, v, last);
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // every word taken, every result seen, then let the block settle
    while (accepted_words < total_words) @(posedge clk);
    while (expected_rsp.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
